// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the allocator back end
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is applied
`define BFA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form of the clocked check
`define BFA_ASSERT_IMPLY(name, ante, cons, msg) \
	`BFA_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// types, codes and constants of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int FRAME_COUNT_DEF = 65536;
	localparam int WORD_BITS_DEF   = 64;

	localparam int CMD_W   = 2;
	localparam int START_W = 16;
	localparam int NUM_W   = 17;
	localparam int FID_W   = 16;
	localparam int CFG_W   = 17;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CFG_W-1:0] RANGE_FIRST_RST = 17'd0;
	localparam logic [CFG_W-1:0] RANGE_LIMIT_RST = 17'd65536;

	// register index as decoded from paddr[2]
	localparam logic REG_RANGE_FIRST = 1'b0;
	localparam logic REG_RANGE_LIMIT = 1'b1;

	// command codes on the input channel
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOMEM = 1'b1;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_MARK,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		BS_CLR,
		BS_IDLE,
		BS_DIV,
		BS_RD,
		BS_SCAN,
		BS_WRD,
		BS_WMOD
	} bst_t;

	typedef struct packed {
		op_t                op;
		logic [START_W-1:0] start;
		logic [NUM_W-1:0]   num;
	} req_t;

	typedef struct packed {
		logic [CFG_W-1:0] first;
		logic [CFG_W-1:0] limit;
	} cfg_t;

endpackage

// ===== rtl/core/bfa_if.sv =====
// ----------------------------------------------------------------------------
// bfa_if
// valid/ready channels of the allocator: commands in, results out
// ----------------------------------------------------------------------------
interface bfa_req_if;
	import bfa_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [START_W-1:0] run_start;
	logic [NUM_W-1:0]   run_len;

	modport source (output valid, cmd, run_start, run_len, input ready);
	modport sink (input valid, cmd, run_start, run_len, output ready);
endinterface

interface bfa_rsp_if;
	import bfa_pkg::*;
	logic             valid;
	logic             ready;
	logic [FID_W-1:0] frame_id;
	logic             status;

	modport source (output valid, frame_id, status, input ready);
	modport sink (input valid, frame_id, status, output ready);
endinterface

// ===== rtl/core/bitmap_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// first-fit page frame allocator over a used-bit map, with apb range registers
// ----------------------------------------------------------------------------
// After reset the unit sweeps the bitmap clear, one word per cycle (MAP_WORDS
// words, 1024 at the default size) and takes no item meanwhile. An item is
// then decoded at the queue head, where an unknown command, an empty run,
// an allocate with an empty range or a run wholly past the map finishes at
// once. Otherwise a reciprocal multiply, then the bit offset, locate its first
// word. Free and mark read each bitmap word they touch and write it back
// through the single memory port. Allocate reads and scans each word, scanning
// again after each used frame it steps over inside a word, then marks the run
// in the same way. The result is offered the cycle after the item finishes,
// and the next item starts only once it has been taken. Items queue two deep
// in front.
module bitmap_frame_allocator_unit import bfa_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bfa_req_if.sink            req,
	bfa_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CFG_W-1:0] range_first_q;
	logic [CFG_W-1:0] range_limit_q;
	cfg_t             cfg;
	logic             q_valid;
	req_t             q_item;
	logic             q_pop;
	logic             clr_busy;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = '{first: range_first_q, limit: range_limit_q};

	// range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= RANGE_FIRST_RST;
			range_limit_q <= RANGE_LIMIT_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_RANGE_FIRST) range_first_q <= pwdata[CFG_W-1:0];
			if (paddr[2] == REG_RANGE_LIMIT) range_limit_q <= pwdata[CFG_W-1:0];
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RANGE_FIRST) prdata = PDATA_W'(range_first_q);
		else prdata = PDATA_W'(range_limit_q);
	end

	bfa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.clr_busy (clr_busy),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	bfa_back #(
		.FRAME_COUNT (FRAME_COUNT),
		.WORD_BITS   (WORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.clr_busy (clr_busy),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/core/bfa_front.sv =====
// ----------------------------------------------------------------------------
// bfa_front
// accepts command items, decodes them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module bfa_front import bfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	bfa_req_if.sink     req,
	input  logic        clr_busy,
	output logic        q_valid,
	output req_t        q_item,
	input  logic        q_pop
);

	localparam int QD = 2;

	req_t       ent_q [QD];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        op_dec;

	// no items while the bitmap is being cleared
	assign req.ready = (cnt_q != 2'(QD)) && !clr_busy;
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = ent_q[rd_ptr_q];

	// command classification
	always_comb begin
		case (req.cmd)
			CMD_ALLOC: op_dec = OP_ALLOC;
			CMD_FREE:  op_dec = OP_FREE;
			CMD_MARK:  op_dec = OP_MARK;
			default:   op_dec = OP_NOP;
		endcase
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{op: op_dec, start: req.run_start, num: req.run_len};
		end
	end

endmodule

// ===== rtl/core/bfa_back.sv =====
// ----------------------------------------------------------------------------
// bfa_back
// bitmap memory, first-fit search and run update engine, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfa_back import bfa_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  req_t        q_item,
	output logic        q_pop,
	output logic        clr_busy,
	bfa_rsp_if.source   rsp
);

	localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BPW = $clog2(WORD_BITS + 1);
	localparam int FCW = $clog2(FRAME_COUNT + 1);
	localparam int FW  = ((FCW > NUM_W) ? FCW : NUM_W) + 1;
	localparam int DL  = $clog2(WORD_BITS);
	localparam int MW  = FW + 2;
	localparam int PW  = FW + MW;
	localparam logic [MW-1:0]        RECIP = MW'(((64'd1 << (FW + DL)) + 64'(WORD_BITS)
		- 64'd1) / 64'(WORD_BITS));
	localparam logic [FW-1:0]        WB_F  = FW'(WORD_BITS);
	localparam logic [BPW-1:0]       WB_B  = BPW'(WORD_BITS);
	localparam logic [FW-1:0]        FC_F  = FW'(FRAME_COUNT);
	localparam logic [AW-1:0]        LAST_A = AW'(MAP_WORDS - 1);
	localparam logic [WORD_BITS-1:0] ONES  = {WORD_BITS{1'b1}};

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	bst_t            state_q, state_d;
	logic [AW-1:0]   clr_q;
	logic            div_cnt_q;
	op_t             op_q;
	logic [FW-1:0]   first_q, hi_q, count_q, lim_q, base_q, run_q;
	logic [FW-1:0]   cand_q, cand_base_q, quo_q;
	logic [AW-1:0]   addr_q, cand_addr_q;
	logic [BPW-1:0]  pos_q;
	logic            out_valid_q, out_status_q;
	logic [FID_W-1:0] out_id_q;

	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_addr;
	logic [WORD_BITS-1:0] mem_wdata;

	// command decode in idle
	logic [FW-1:0]   lim_eff, run_end, run_hi, in_first;
	logic            start_ok, pop_go, pop_fin;
	logic [FID_W-1:0] pop_id;
	logic            pop_status;

	// division by the word size
	logic [PW-1:0]   div_prod;
	logic [FW-1:0]   div_quo, div_mul, div_rem_f;
	logic [BPW-1:0]  div_rem;
	logic            div_last;

	// scan of one word
	logic [WORD_BITS-1:0] used_m;
	logic            has_u, u_last, fit, fit_ok, reach;
	logic [BPW-1:0]  u_idx, seg_end, seg_len;
	logic [FW-1:0]   end_frame, run_tot, cand_end;

	// word update
	logic [FW-1:0]   lo_diff, hi_diff;
	logic [BPW-1:0]  lo_off, hi_off;
	logic [WORD_BITS-1:0] wmask, wmask_hi;
	logic            wr_last;

	logic            fin, fin_status;
	logic [FID_W-1:0] fin_id;

	assign clr_busy = (state_q == BS_CLR);

	// idle decode of the item at the queue head
	always_comb begin
		lim_eff  = (FW'(cfg.limit) < FC_F) ? FW'(cfg.limit) : FC_F;
		run_end  = FW'(q_item.start) + FW'(q_item.num);
		run_hi   = (run_end < FC_F) ? run_end : FC_F;
		in_first = (q_item.op == OP_ALLOC) ? FW'(cfg.first) : FW'(q_item.start);
		pop_id     = '0;
		pop_status = STATUS_OK;
		start_ok   = 1'b0;
		case (q_item.op)
			OP_ALLOC: begin
				if (q_item.num == '0) begin
					pop_id = cfg.first[FID_W-1:0];
				end else if (FW'(cfg.first) >= lim_eff) begin
					pop_status = STATUS_NOMEM;
				end else begin
					start_ok = 1'b1;
				end
			end
			OP_FREE, OP_MARK: begin
				start_ok = (FW'(q_item.start) < run_hi);
			end
			default: begin
				start_ok = 1'b0;
			end
		endcase
		pop_go  = (state_q == BS_IDLE) && q_valid && !out_valid_q;
		pop_fin = pop_go && !start_ok;
	end

	// word index by reciprocal multiply, then the bit offset
	always_comb begin
		div_prod  = PW'(first_q) * PW'(RECIP);
		div_quo   = FW'(div_prod >> (FW + DL));
		div_mul   = quo_q * WB_F;
		div_rem_f = first_q - div_mul;
		div_rem   = div_rem_f[BPW-1:0];
		div_last  = div_cnt_q;
	end

	// first used bit at or above the scan position
	always_comb begin
		used_m = rdata_q & (ONES << pos_q);
		has_u  = |used_m;
		u_idx  = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (used_m[i]) u_idx = BPW'(i);
		end
		seg_end   = has_u ? u_idx : WB_B;
		seg_len   = seg_end - pos_q;
		end_frame = base_q + FW'(seg_end);
		run_tot   = run_q + FW'(seg_len);
		cand_end  = cand_q + count_q;
		fit       = (run_tot >= count_q);
		fit_ok    = (cand_end <= lim_q);
		reach     = (end_frame >= lim_q);
		u_last    = (u_idx == BPW'(WORD_BITS - 1));
	end

	// bit mask of the run inside the current word
	always_comb begin
		lo_diff  = first_q - base_q;
		hi_diff  = hi_q - base_q;
		lo_off   = (first_q > base_q) ? lo_diff[BPW-1:0] : '0;
		hi_off   = (hi_diff >= WB_F) ? WB_B : hi_diff[BPW-1:0];
		wmask_hi = (hi_off == WB_B) ? ONES : ~(ONES << hi_off);
		wmask    = (ONES << lo_off) & wmask_hi;
		wr_last  = (base_q + WB_F >= hi_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_CLR:  if (clr_q == LAST_A) state_d = BS_IDLE;
			BS_IDLE: if (pop_go && start_ok) state_d = BS_DIV;
			BS_DIV:  if (div_last) state_d = (op_q == OP_ALLOC) ? BS_RD : BS_WRD;
			BS_RD:   state_d = BS_SCAN;
			BS_SCAN: begin
				if (fit) state_d = fit_ok ? BS_WRD : BS_IDLE;
				else if (reach) state_d = BS_IDLE;
				else if (has_u && !u_last) state_d = BS_SCAN;
				else state_d = BS_RD;
			end
			BS_WRD:  state_d = BS_WMOD;
			BS_WMOD: state_d = wr_last ? BS_IDLE : BS_WRD;
			default: state_d = BS_IDLE;
		endcase
	end

	// outputs: memory port, queue pop, finished result
	always_comb begin
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = addr_q;
		mem_wdata  = '0;
		q_pop      = 1'b0;
		fin        = 1'b0;
		fin_id     = '0;
		fin_status = STATUS_OK;
		case (state_q)
			BS_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			BS_IDLE: begin
				q_pop      = pop_go;
				fin        = pop_fin;
				fin_id     = pop_id;
				fin_status = pop_status;
			end
			BS_RD, BS_WRD: begin
				mem_re = 1'b1;
			end
			BS_SCAN: begin
				if ((fit && !fit_ok) || (!fit && reach)) begin
					fin        = 1'b1;
					fin_status = STATUS_NOMEM;
				end
			end
			BS_WMOD: begin
				mem_we    = 1'b1;
				mem_wdata = (op_q == OP_FREE) ? (rdata_q & ~wmask) : (rdata_q | wmask);
				if (wr_last) begin
					fin    = 1'b1;
					fin_id = (op_q == OP_ALLOC) ? first_q[FID_W-1:0] : '0;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_CLR;
			clr_q       <= '0;
			div_cnt_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BS_CLR) clr_q <= clr_q + AW'(1);
			if (state_q == BS_DIV) div_cnt_q <= ~div_cnt_q;
			else div_cnt_q <= 1'b0;
			if (fin) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin) begin
			out_id_q     <= fin_id;
			out_status_q <= fin_status;
		end
		case (state_q)
			BS_IDLE: begin
				op_q     <= q_item.op;
				first_q  <= in_first;
				hi_q     <= run_hi;
				count_q  <= FW'(q_item.num);
				lim_q    <= lim_eff;
			end
			BS_DIV: begin
				if (!div_last) begin
					quo_q <= div_quo;
				end else begin
					addr_q      <= quo_q[AW-1:0];
					base_q      <= div_mul;
					pos_q       <= div_rem;
					cand_q      <= first_q;
					cand_addr_q <= quo_q[AW-1:0];
					cand_base_q <= div_mul;
					run_q       <= '0;
				end
			end
			BS_SCAN: begin
				if (fit) begin
					first_q <= cand_q;
					hi_q    <= cand_end;
					addr_q  <= cand_addr_q;
					base_q  <= cand_base_q;
				end else if (has_u) begin
					run_q  <= '0;
					cand_q <= base_q + FW'(u_idx) + FW'(1);
					if (u_last) begin
						addr_q      <= addr_q + AW'(1);
						base_q      <= base_q + WB_F;
						pos_q       <= '0;
						cand_addr_q <= addr_q + AW'(1);
						cand_base_q <= base_q + WB_F;
					end else begin
						pos_q       <= u_idx + BPW'(1);
						cand_addr_q <= addr_q;
						cand_base_q <= base_q;
					end
				end else begin
					run_q  <= run_tot;
					addr_q <= addr_q + AW'(1);
					base_q <= base_q + WB_F;
					pos_q  <= '0;
				end
			end
			BS_WMOD: begin
				addr_q <= addr_q + AW'(1);
				base_q <= base_q + WB_F;
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.frame_id = out_id_q;
	assign rsp.status   = out_status_q;

	`BFA_ASSERT_IMPLY(a_pop_when_free, q_pop, (state_q == BS_IDLE) && !out_valid_q, "pop while busy")
	`BFA_ASSERT_IMPLY(a_write_phase, mem_we, (state_q == BS_CLR) || (state_q == BS_WMOD), "stray bitmap write")
	`BFA_ASSERT_IMPLY(a_fail_zero, fin && (fin_status == STATUS_NOMEM), fin_id == '0, "failed item with frame")
	`BFA_ASSERT(a_result_holds, out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_id_q), "result lost")

endmodule
